// ===== hdl/evs_pkg.sv =====
`timescale 1ns / 1ps

package evs_pkg;

  localparam int SEGMENT_DEPTH = 16384;
  localparam int CHUNK_MAX     = 4096;

  localparam int ADDR_W   = $clog2(SEGMENT_DEPTH);
  localparam int SEG_W    = $clog2(SEGMENT_DEPTH + 1);
  localparam int CNT_W    = $clog2(CHUNK_MAX + 1);
  localparam int SMP_W    = 16;
  localparam int SQ_W     = 31;
  localparam int ENERGY_W = 43;
  localparam int THR_W    = 31;
  localparam int MS_W     = 16;
  localparam int TIME_W   = 32;
  localparam int MAXSEG_W = 15;
  localparam int LEN_W    = 15;
  localparam int RIDX_W   = 14;
  localparam int EV_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam int PROD_W   = THR_W + CNT_W;

  localparam logic [THR_W-1:0]    START_ENERGY_RST = THR_W'(966368);
  localparam logic [THR_W-1:0]    STOP_ENERGY_RST  = THR_W'(241592);
  localparam logic [MS_W-1:0]     SILENCE_MS_RST   = MS_W'(250);
  localparam logic [MS_W-1:0]     COOLDOWN_MS_RST  = MS_W'(500);
  localparam logic [MAXSEG_W-1:0] MAX_SEGMENT_RST  = MAXSEG_W'(16000);

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_STARTED = 2'd1;
  localparam logic [EV_W-1:0] EV_STOPPED = 2'd2;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ENERGY = 3'd0,
    REG_STOP_ENERGY  = 3'd1,
    REG_SILENCE_MS   = 3'd2,
    REG_COOLDOWN_MS  = 3'd3,
    REG_MAX_SEGMENT  = 3'd4
  } cfg_reg_t;

endpackage

// ===== hdl/energy_vad_segmenter_top.sv =====
`timescale 1ns / 1ps

// Energy voice-activity segmenter: takes one 16-bit sample or one store read per cycle,
// sums squared samples over each chunk (closed by tlast), starts a segment when the
// chunk energy reaches start_energy times the sample count after the cooldown, keeps it
// alive at stop_energy, and ends it on silence timeout or a full segment. Each chunk end
// and each read gives one result, registered first in the s1 stage and then in the output
// register; the s1 stage covers the registered read port of the segment store, and the
// input side takes a new item every cycle as long as the result side drains. Samples are
// written to the store as they arrive; a chunk that does not belong to a segment leaves
// its words in the store. The store has no reset: read only positions written since reset.
module energy_vad_segmenter_top
  import evs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [15:0] sample, [47:16] now_ms, [61:48] read_index, [63:62] zero
  input  logic [63:0]           in_tdata,
  // [0] op
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [14:0] segment_length, [30:15] read_data, [31] zero
  output logic [31:0]           out_tdata,
  // [1:0] event_res
  output logic [EV_W-1:0]       out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [THR_W-1:0]    start_energy_r;
  logic [THR_W-1:0]    stop_energy_r;
  logic [MS_W-1:0]     silence_ms_r;
  logic [MS_W-1:0]     cooldown_ms_r;
  logic [MAXSEG_W-1:0] max_segment_r;

  logic                recording_r, recording_nxt;
  logic [SEG_W-1:0]    seg_count_r, seg_count_nxt;
  logic [CNT_W-1:0]    chunk_count_r, chunk_count_nxt;
  logic [ENERGY_W-1:0] energy_sum_r, energy_sum_nxt;
  logic [TIME_W-1:0]   last_loud_r, last_loud_nxt;
  logic [TIME_W-1:0]   last_detect_r, last_detect_nxt;

  logic                s1_valid_r;
  logic [EV_W-1:0]     s1_ev_r, s1_ev_nxt;
  logic [LEN_W-1:0]    s1_len_r, s1_len_nxt;
  logic                s1_rd_r;

  logic                out_valid_r;
  logic [EV_W-1:0]     out_ev_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [SMP_W-1:0]    out_rd_r;

  logic                accept, s1_adv;
  op_t                 op;
  logic signed [SMP_W-1:0] smp;
  logic [TIME_W-1:0]   now_ms;
  logic [RIDX_W-1:0]   ridx;
  logic                is_read, is_sample, chunk_end, rd_in_range;

  logic signed [31:0]  sq_s;
  logic [SQ_W-1:0]     sq;
  logic                counted;
  logic [ENERGY_W:0]   sum_wide;
  logic [ENERGY_W-1:0] sum_cur;
  logic [CNT_W-1:0]    n;
  logic [PROD_W-1:0]   start_prod, stop_prod;
  logic [SEG_W-1:0]    cap;
  logic [SEG_W:0]      pos;
  logic                wr_en;
  logic [SMP_W-1:0]    ram_rdata;

  logic                do_start, rec1, do_stop;
  logic [SEG_W-1:0]    seg0, room, take, seg1;
  logic [TIME_W-1:0]   ll1;

  assign op        = op_t'(in_tuser);
  assign smp       = in_tdata[15:0];
  assign now_ms    = in_tdata[47:16];
  assign ridx      = in_tdata[61:48];

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || !out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign is_read   = accept && (op == OP_READ);
  assign is_sample = accept && (op == OP_SAMPLE);
  assign chunk_end = is_sample && in_tlast;
  assign rd_in_range = 32'(ridx) < SEGMENT_DEPTH;

  assign sq_s     = smp * smp;
  assign sq       = sq_s[SQ_W-1:0];
  assign counted  = 32'(chunk_count_r) < CHUNK_MAX;
  assign sum_wide = {1'b0, energy_sum_r} + (ENERGY_W + 1)'(counted ? sq : '0);
  assign sum_cur  = sum_wide[ENERGY_W] ? ENERGY_MAX : sum_wide[ENERGY_W-1:0];
  assign n        = chunk_count_r + CNT_W'(counted);

  assign start_prod = PROD_W'(start_energy_r) * PROD_W'(n);
  assign stop_prod  = PROD_W'(stop_energy_r) * PROD_W'(n);

  assign cap   = (32'(max_segment_r) < SEGMENT_DEPTH) ? SEG_W'(max_segment_r)
                                                      : SEG_W'(SEGMENT_DEPTH);
  assign pos   = (SEG_W + 1)'(seg_count_r) + (SEG_W + 1)'(chunk_count_r);
  assign wr_en = is_sample && counted && (pos < (SEG_W + 1)'(cap));

  evs_ram #(
    .WIDTH(SMP_W),
    .DEPTH(SEGMENT_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(pos[ADDR_W-1:0]),
    .wdata(smp),
    .re   (is_read),
    .raddr(ADDR_W'(ridx)),
    .rdata(ram_rdata)
  );

  always_comb begin
    do_start = !recording_r && (PROD_W'(sum_cur) >= start_prod)
               && ((now_ms - last_detect_r) > TIME_W'(cooldown_ms_r));
    rec1     = recording_r || do_start;
    seg0     = do_start ? '0 : seg_count_r;
    room     = (cap > seg0) ? (cap - seg0) : '0;
    take     = (32'(n) < 32'(room)) ? SEG_W'(n) : room;
    seg1     = seg0 + take;
    ll1      = do_start ? now_ms : last_loud_r;
    if (rec1 && (PROD_W'(sum_cur) >= stop_prod)) begin
      ll1 = now_ms;
    end
    do_stop  = rec1 && (((now_ms - ll1) > TIME_W'(silence_ms_r)) || (seg1 >= cap));

    recording_nxt   = recording_r;
    seg_count_nxt   = seg_count_r;
    chunk_count_nxt = chunk_count_r;
    energy_sum_nxt  = energy_sum_r;
    last_loud_nxt   = last_loud_r;
    last_detect_nxt = last_detect_r;
    s1_ev_nxt       = EV_NONE;
    s1_len_nxt      = LEN_W'(seg_count_r);

    if (is_sample) begin
      if (in_tlast) begin
        chunk_count_nxt = '0;
        energy_sum_nxt  = '0;
        if (rec1) begin
          last_loud_nxt = ll1;
          s1_len_nxt    = LEN_W'(seg1);
          if (do_stop) begin
            recording_nxt   = 1'b0;
            seg_count_nxt   = '0;
            last_detect_nxt = now_ms;
          end else begin
            recording_nxt = 1'b1;
            seg_count_nxt = seg1;
          end
        end
        s1_ev_nxt = (do_start ? EV_STARTED : EV_NONE) | (do_stop ? EV_STOPPED : EV_NONE);
      end else begin
        chunk_count_nxt = n;
        energy_sum_nxt  = sum_cur;
      end
    end
  end

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_energy_r <= START_ENERGY_RST;
      stop_energy_r  <= STOP_ENERGY_RST;
      silence_ms_r   <= SILENCE_MS_RST;
      cooldown_ms_r  <= COOLDOWN_MS_RST;
      max_segment_r  <= MAX_SEGMENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_ENERGY: start_energy_r <= cfg_data[THR_W-1:0];
        REG_STOP_ENERGY:  stop_energy_r  <= cfg_data[THR_W-1:0];
        REG_SILENCE_MS:   silence_ms_r   <= cfg_data[MS_W-1:0];
        REG_COOLDOWN_MS:  cooldown_ms_r  <= cfg_data[MS_W-1:0];
        REG_MAX_SEGMENT:  max_segment_r  <= cfg_data[MAXSEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recording_r   <= 1'b0;
      seg_count_r   <= '0;
      chunk_count_r <= '0;
      energy_sum_r  <= '0;
      last_loud_r   <= '0;
      last_detect_r <= '0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      recording_r   <= recording_nxt;
      seg_count_r   <= seg_count_nxt;
      chunk_count_r <= chunk_count_nxt;
      energy_sum_r  <= energy_sum_nxt;
      last_loud_r   <= last_loud_nxt;
      last_detect_r <= last_detect_nxt;
      if (is_read || chunk_end) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_read || chunk_end) begin
      s1_ev_r  <= s1_ev_nxt;
      s1_len_r <= s1_len_nxt;
      s1_rd_r  <= is_read && rd_in_range;
    end
    if (s1_adv) begin
      out_ev_r  <= s1_ev_r;
      out_len_r <= s1_len_r;
      out_rd_r  <= s1_rd_r ? ram_rdata : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tdata  = {1'b0, out_rd_r, out_len_r};

endmodule

// ===== hdl/evs_ram.sv =====
`timescale 1ns / 1ps

module evs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/energy_vad_segmenter_top_tb.sv =====
`timescale 1ns / 1ps

module energy_vad_segmenter_top_tb;
  import evs_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [EV_W-1:0]  ev;
    logic [LEN_W-1:0] len;
    logic [SMP_W-1:0] rdata;
  } vad_result_t;

  class vad_scoreboard;
    logic [THR_W-1:0]    start_thr;
    logic [THR_W-1:0]    stop_thr;
    logic [MS_W-1:0]     silence_ms;
    logic [MS_W-1:0]     cooldown_ms;
    logic [MAXSEG_W-1:0] max_seg;
    bit                  recording;
    longint unsigned     seg_count;
    longint unsigned     chunk_count;
    longint unsigned     energy;
    logic [TIME_W-1:0]   last_loud_ms;
    logic [TIME_W-1:0]   last_detect_ms;
    logic [SMP_W-1:0]    store [SEGMENT_DEPTH];
    bit                  written [SEGMENT_DEPTH];
    int                  written_pos [$];
    vad_result_t         due_results [$];
    int                  errors;

    function new();
      start_thr      = START_ENERGY_RST;
      stop_thr       = STOP_ENERGY_RST;
      silence_ms     = SILENCE_MS_RST;
      cooldown_ms    = COOLDOWN_MS_RST;
      max_seg        = MAX_SEGMENT_RST;
      recording      = 1'b0;
      seg_count      = 0;
      chunk_count    = 0;
      energy         = 0;
      last_loud_ms   = '0;
      last_detect_ms = '0;
      errors         = 0;
    endfunction

    function void apply_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_START_ENERGY: start_thr   = val[THR_W-1:0];
        REG_STOP_ENERGY:  stop_thr    = val[THR_W-1:0];
        REG_SILENCE_MS:   silence_ms  = val[MS_W-1:0];
        REG_COOLDOWN_MS:  cooldown_ms = val[MS_W-1:0];
        REG_MAX_SEGMENT:  max_seg     = val[MAXSEG_W-1:0];
        default: ;
      endcase
    endfunction

    function void advance_detector(op_t op, logic [SMP_W-1:0] smp, logic chunk_end,
                                   logic [TIME_W-1:0] now, logic [RIDX_W-1:0] ridx);
      vad_result_t       r;
      longint unsigned   cap, sq, sum, room, n, pos;
      longint            sv;
      logic [TIME_W-1:0] dt;
      r.ev    = EV_NONE;
      r.len   = '0;
      r.rdata = '0;
      cap = (max_seg < SEGMENT_DEPTH) ? max_seg : SEGMENT_DEPTH;
      if (op == OP_READ) begin
        r.len   = LEN_W'(seg_count);
        r.rdata = store[ridx];
        due_results.push_back(r);
        return;
      end
      if (chunk_count < CHUNK_MAX) begin
        sv  = $signed(smp);
        sq  = sv * sv;
        pos = seg_count + chunk_count;
        if (pos < cap) begin
          store[pos] = smp;
          if (!written[pos]) begin
            written[pos] = 1'b1;
            written_pos.push_back(int'(pos));
          end
        end
        energy = (ENERGY_MAX - energy < sq) ? ENERGY_MAX : energy + sq;
        chunk_count++;
      end
      if (!chunk_end) return;

      n           = chunk_count;
      sum         = energy;
      chunk_count = 0;
      energy      = 0;
      if (!recording) begin
        dt = now - last_detect_ms;
        if (sum >= start_thr * n && dt > cooldown_ms) begin
          recording    = 1'b1;
          seg_count    = 0;
          last_loud_ms = now;
          r.ev         = r.ev | EV_STARTED;
        end
      end
      r.len = LEN_W'(seg_count);
      if (recording) begin
        room = (cap > seg_count) ? cap - seg_count : 0;
        seg_count += (n < room) ? n : room;
        if (sum >= stop_thr * n) last_loud_ms = now;
        r.len = LEN_W'(seg_count);
        dt = now - last_loud_ms;
        if (dt > silence_ms || seg_count >= cap) begin
          r.ev           = r.ev | EV_STOPPED;
          last_detect_ms = now;
          seg_count      = 0;
          recording      = 1'b0;
        end
      end
      due_results.push_back(r);
    endfunction

    function void match_result(logic [EV_W-1:0] ev, logic [LEN_W-1:0] len,
                               logic [SMP_W-1:0] rdata);
      vad_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected transfer: event_res %0d segment_length %0d read_data %0d",
               ev, len, $signed(rdata));
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (ev !== want.ev) begin
        $error("event_res: expected %0d, actual %0d", want.ev, ev);
        errors++;
      end
      if (len !== want.len) begin
        $error("segment_length: expected %0d, actual %0d", want.len, len);
        errors++;
      end
      if (rdata !== want.rdata) begin
        $error("read_data: expected %0d, actual %0d", $signed(want.rdata), $signed(rdata));
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [63:0]           in_tdata;
  logic                  in_tuser;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic [EV_W-1:0]       out_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int                send_gap_pct;
  int                stall_pct;
  int                read_pct;
  int                quiet_cycles;
  logic [TIME_W-1:0] clock_ms;
  vad_scoreboard     sb;

  energy_vad_segmenter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready)
        sb.match_result(out_tuser, out_tdata[LEN_W-1:0], out_tdata[LEN_W+SMP_W-1:LEN_W]);
      if (in_tvalid && in_tready)
        sb.advance_detector(op_t'(in_tuser), in_tdata[SMP_W-1:0], in_tlast,
                            in_tdata[SMP_W+TIME_W-1:SMP_W],
                            in_tdata[SMP_W+TIME_W+RIDX_W-1:SMP_W+TIME_W]);
      if (cfg_valid && cfg_ready)
        sb.apply_reg(cfg_reg_t'(cfg_index), cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [SMP_W-1:0] pick_sample(int unsigned lo, int unsigned hi);
    int mag;
    mag = $urandom_range(hi, lo);
    if (mag == 32768 || $urandom_range(1) == 1) return SMP_W'(-mag);
    return SMP_W'(mag);
  endfunction

  task automatic send_item(input op_t op, input logic [SMP_W-1:0] smp, input logic chunk_end,
                           input logic [TIME_W-1:0] now, input logic [RIDX_W-1:0] ridx);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= chunk_end;
    in_tdata  <= {2'b00, ridx, now, smp};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_read();
    logic [RIDX_W-1:0] idx;
    if (sb.written_pos.size() == 0) return;
    idx = RIDX_W'(sb.written_pos[$urandom_range(sb.written_pos.size() - 1)]);
    send_item(OP_READ, SMP_W'($urandom), 1'($urandom), $urandom, idx);
  endtask

  task automatic send_chunk(input int n, input int unsigned lo, input int unsigned hi,
                            input logic [TIME_W-1:0] t);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < read_pct) send_read();
      send_item(OP_SAMPLE, pick_sample(lo, hi), i == n - 1, (i == n - 1) ? t : $urandom,
                RIDX_W'($urandom));
    end
  endtask

  // hold off until every result is in, then let the pipeline settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] start_v, stop_v, silence_v,
                              cooldown_v, maxseg_v);
    cfg_reg_t              regs [5];
    logic [CFG_DATA_W-1:0] vals [5];
    regs = '{REG_START_ENERGY, REG_STOP_ENERGY, REG_SILENCE_MS, REG_COOLDOWN_MS,
             REG_MAX_SEGMENT};
    vals = '{start_v, stop_v, silence_v, cooldown_v, maxseg_v};
    foreach (regs[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int samples);
    int unsigned           sa, so, lo, hi, n, kind;
    logic [CFG_DATA_W-1:0] start_v, stop_v, silence_v, cooldown_v, maxseg_v;
    int                    sent;
    sa      = $urandom_range(12000, 100);
    so      = $urandom_range(sa, 10);
    start_v = CFG_DATA_W'(sa * sa);
    stop_v  = CFG_DATA_W'(so * so);
    if ($urandom_range(4) == 0) begin
      start_v = CFG_DATA_W'($urandom_range(1 << 30, 0));
      stop_v  = CFG_DATA_W'($urandom_range(1 << 30, 0));
    end
    silence_v  = CFG_DATA_W'(($urandom_range(7) == 0) ? 65535 : $urandom_range(400, 0));
    cooldown_v = CFG_DATA_W'(($urandom_range(7) == 0) ? 0 : $urandom_range(600, 0));
    case ($urandom_range(19))
      0: maxseg_v = 0;
      1: maxseg_v = CFG_DATA_W'(SEGMENT_DEPTH);
      2, 3, 4, 5, 6, 7, 8, 9: maxseg_v = CFG_DATA_W'($urandom_range(40, 1));
      default: maxseg_v = CFG_DATA_W'($urandom_range(400, 41));
    endcase
    program_regs(start_v, stop_v, silence_v, cooldown_v, maxseg_v);
    sent = 0;
    while (sent < samples) begin
      n    = ($urandom_range(15) == 0) ? $urandom_range(64, 1) : $urandom_range(12, 1);
      kind = $urandom_range(9);
      if (kind < 4) begin
        lo = sa;
        hi = 32768;
      end else if (kind < 7) begin
        lo = so;
        hi = sa;
      end else if (kind < 9) begin
        lo = 0;
        hi = so - 1;
      end else begin
        lo = 0;
        hi = 32768;
      end
      clock_ms = clock_ms + (($urandom_range(39) == 0) ? $urandom : $urandom_range(120, 0));
      send_chunk(n, lo, hi, clock_ms);
      sent += n;
    end
    drain();
  endtask

  initial begin
    sb           = new();
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_SAMPLE;
    in_tlast     = 1'b0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_START_ENERGY;
    cfg_data     = '0;
    quiet_cycles = 0;
    send_gap_pct = 8;
    stall_pct    = 48;
    read_pct     = 10;
    clock_ms     = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset thresholds: start, silence stop, cooldown block, tentative words
    send_item(OP_SAMPLE, 16'h8000, 1'b0, $urandom, '0);
    send_item(OP_SAMPLE, 16'h7fff, 1'b1, 32'd600, '0);
    send_item(OP_READ, SMP_W'($urandom), 1'b1, $urandom, '0);
    send_item(OP_SAMPLE, 16'h0000, 1'b1, 32'd700, '0);
    send_item(OP_SAMPLE, 16'h0000, 1'b1, 32'd1000, '0);
    send_item(OP_SAMPLE, 16'h7fff, 1'b1, 32'd1200, '0);
    send_item(OP_READ, SMP_W'($urandom), 1'b0, $urandom, '0);
    drain();

    // empty store: start and stop in the same chunk
    program_regs(0, 1 << 30, 0, 0, 0);
    send_item(OP_SAMPLE, SMP_W'($urandom), 1'b1, 32'd1300, '0);
    drain();

    // top thresholds, one-word store, time wrap
    program_regs(1 << 30, 0, 65535, 65535, 1);
    send_item(OP_SAMPLE, 16'h8000, 1'b0, $urandom, '0);
    send_item(OP_SAMPLE, 16'h8000, 1'b1, 32'hffff_0000, '0);
    send_item(OP_SAMPLE, 16'h8000, 1'b1, 32'h0000_8000, '0);
    send_item(OP_SAMPLE, 16'h7fff, 1'b1, 32'h0002_0000, '0);
    send_item(OP_READ, SMP_W'($urandom), 1'b1, $urandom, '0);
    drain();
    clock_ms = 32'h0002_0000;

    run_phase(260);
    run_phase(260);
    send_gap_pct = 48;
    stall_pct    = 8;
    run_phase(260);
    run_phase(260);
    send_gap_pct = 0;
    stall_pct    = 0;
    run_phase(260);
    run_phase(260);

    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
